>>> src/csit_pkg.sv
// csit_pkg: shared constants and types for the combining sequence intern table.
// No dependencies.
`timescale 1ns / 1ps
package csit_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [31:0] CODE_BASE = 32'h8000_0000;
    localparam logic [3:0] LEN_CAP = 4'd15;
    localparam logic [3:0] MAX_PREFIX_RESET = 4'd10;
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the request
        logic rd_code;    // read entry named by seq_code
        logic cap_code;   // capture that read
        logic rd_scan;    // read entry at scan index
        logic chk_scan;   // compare scan read, advance index
        logic write;      // allocate new entry
        logic emit;       // drive the result strobe
    } csit_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic composite;
        logic code_ok;
        logic is_query;
        logic scan_done;  // scan index reached fill count
        logic hit;
        logic can_alloc;
    } csit_sts_t;
endpackage

>>> src/combining_sequence_intern_table.sv
// combining_sequence_intern_table: top level with APB register and handshake.
// Depends on csit_pkg, csit_ctrl, csit_datapath.
`timescale 1ns / 1ps
// Interns base-plus-combining-mark sequences as 32-bit codes. A transfer is
// taken when start is high and busy low; its single result appears on the
// result ports for one cycle with done high and cannot be stalled. Timing is
// set by the linear pair scan over the entry memory (one registered read port):
// a query reads at most one entry; an append scans used entries until a hit.
// No clearing pass is needed: entries past the fill count are never read.
module combining_sequence_intern_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] seq_code,
    input  logic [20:0] mark_char,
    output logic        done,
    output logic [31:0] result_code,
    output logic [31:0] base_char,
    output logic [3:0]  seq_length,
    output logic        was_new,
    output logic        refused,
    output logic        invalid
);
    import csit_pkg::*;

    csit_cmd_t  cmd;
    csit_sts_t  sts;
    logic [3:0] max_len_reg;

    // single register at address 0; writes to address 1 are dropped, reads ignore paddr
    assign pready = 1'b1;
    assign prdata = {28'd0, max_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_PREFIX_RESET;
        else if (psel && penable && pwrite && (paddr == 1'b0))
            max_len_reg <= pwdata[3:0];
    end

    csit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    csit_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .seq_code    (seq_code),
        .mark_char   (mark_char),
        .max_len     (max_len_reg),
        .result_code (result_code),
        .base_char   (base_char),
        .seq_length  (seq_length),
        .was_new     (was_new),
        .refused     (refused),
        .invalid     (invalid),
        .done        (done)
    );

    // a result flag set is exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({was_new, refused, invalid}))
        else $error("result flags not exclusive");
    // every accepted request leaves busy raised next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");
    // an allocation always produces a result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> cmd.emit)
        else $error("write without result");
endmodule

>>> src/csit_datapath.sv
// csit_datapath: entry memories, fill count, scan compare and result registers.
// Depends on csit_pkg.
`timescale 1ns / 1ps
module csit_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  csit_pkg::csit_cmd_t cmd,
    output csit_pkg::csit_sts_t sts,
    input  logic                func,
    input  logic [31:0]         seq_code,
    input  logic [20:0]         mark_char,
    input  logic [3:0]          max_len,
    output logic [31:0]         result_code,
    output logic [31:0]         base_char,
    output logic [3:0]          seq_length,
    output logic                was_new,
    output logic                refused,
    output logic                invalid,
    output logic                done
);
    import csit_pkg::*;

    // one row: prefix, suffix, base, length
    typedef struct packed {
        logic [31:0] prefix;
        logic [20:0] suffix;
        logic [20:0] base;
        logic [3:0]  len;
    } entry_t;

    entry_t             mem [TABLE_ENTRIES];
    entry_t             rd_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic               func_reg;
    logic [31:0]        code_reg;
    logic [20:0]        mark_reg;
    logic [31:0]        base_reg;
    logic [3:0]         len_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [31:0]        idx_n;
    logic               composite;
    logic               code_ok;
    logic               match;

    assign composite = code_reg >= CODE_BASE;
    assign idx_n     = code_reg - CODE_BASE;
    assign code_ok   = (idx_n != 32'd0) && (idx_n <= 32'(used_reg));
    assign match     = (rd_reg.prefix == code_reg) && (rd_reg.suffix == mark_reg);

    always_comb
    begin
        if (cmd.rd_code)
            rd_addr = IDX_W'(idx_n - 32'd1);
        else
            rd_addr = scan_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
            mem[used_reg[IDX_W-1:0]] <= '{prefix: code_reg, suffix: mark_reg,
                                         base: base_reg[20:0], len: len_reg + 4'd1};
        if (cmd.rd_code || cmd.rd_scan)
            rd_reg <= mem[rd_addr];
    end

    assign sts.composite = composite;
    assign sts.code_ok   = code_ok;
    assign sts.is_query  = func_reg == FUNC_QUERY;
    assign sts.scan_done = scan_reg >= used_reg;
    assign sts.hit       = hit_reg;
    assign sts.can_alloc = (len_reg <= max_len) && (len_reg != LEN_CAP)
                           && (used_reg < CNT_W'(TABLE_ENTRIES))
                           && (base_reg[31:21] == 11'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            done        <= 1'b0;
            scan_reg    <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        else
        begin
            done <= cmd.emit;
            if (cmd.write)
                used_reg <= used_reg + CNT_W'(1);
            if (cmd.load)
            begin
                scan_reg <= '0;
                hit_reg  <= 1'b0;
            end
            if (cmd.chk_scan && !hit_reg)
            begin
                if (match)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= scan_reg[IDX_W-1:0];
                end
                scan_reg <= scan_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            code_reg <= seq_code;
            mark_reg <= mark_char;
            base_reg <= seq_code;
            len_reg  <= 4'd1;
        end
        if (cmd.cap_code)
        begin
            base_reg <= {11'd0, rd_reg.base};
            len_reg  <= rd_reg.len;
        end
        if (cmd.emit)
        begin
            was_new <= 1'b0;
            refused <= 1'b0;
            invalid <= 1'b0;
            result_code <= code_reg;
            base_char   <= base_reg;
            seq_length  <= len_reg;
            if (composite && !code_ok)
            begin
                invalid    <= 1'b1;
                base_char  <= code_reg;
                seq_length <= 4'd1;
            end
            else if (func_reg == FUNC_QUERY)
            begin
                // composite query: entry read lands in the same cycle
                if (cmd.cap_code)
                begin
                    base_char  <= {11'd0, rd_reg.base};
                    seq_length <= rd_reg.len;
                end
            end
            else if (hit_reg)
            begin
                result_code <= CODE_BASE + 32'(hit_idx_reg) + 32'd1;
                base_char   <= {11'd0, rd_reg.base};
                seq_length  <= rd_reg.len;
            end
            else if (cmd.write)
            begin
                was_new     <= 1'b1;
                result_code <= CODE_BASE + 32'(used_reg) + 32'd1;
                seq_length  <= len_reg + 4'd1;
            end
            else
                refused <= 1'b1;
        end
    end
endmodule

>>> src/csit_ctrl.sv
// csit_ctrl: sequencer for code lookup, linear pair scan and allocation.
// Depends on csit_pkg.
`timescale 1ns / 1ps
module csit_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  csit_pkg::csit_sts_t sts,
    output csit_pkg::csit_cmd_t cmd
);
    import csit_pkg::*;

    typedef enum logic [2:0] {IDLE, DECODE, CODE_RD, SCAN_RD, SCAN_CHK, FINISH}
        state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            IDLE:
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = DECODE;
                end
            DECODE:
                if (sts.composite && !sts.code_ok)
                begin
                    cmd.emit = 1'b1;
                    state_next = FINISH;
                end
                else if (sts.composite)
                begin
                    cmd.rd_code = 1'b1;
                    state_next = CODE_RD;
                end
                else if (sts.is_query)
                begin
                    cmd.emit = 1'b1;
                    state_next = FINISH;
                end
                else
                    state_next = SCAN_RD;
            CODE_RD:
            begin
                cmd.cap_code = 1'b1;
                if (sts.is_query)
                begin
                    cmd.emit = 1'b1;
                    state_next = FINISH;
                end
                else
                    state_next = SCAN_RD;
            end
            SCAN_RD:
                if (sts.hit)
                begin
                    cmd.emit = 1'b1;   // read register still holds the matching row
                    state_next = FINISH;
                end
                else if (sts.scan_done)
                begin
                    cmd.emit  = 1'b1;
                    cmd.write = sts.can_alloc;
                    state_next = FINISH;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next = SCAN_CHK;
                end
            SCAN_CHK:
            begin
                cmd.chk_scan = 1'b1;
                state_next = SCAN_RD;
            end
            FINISH:
                state_next = IDLE;
            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != IDLE;
endmodule

>>> sim/combining_sequence_intern_table_tb.sv
// combining_sequence_intern_table_tb: self-checking bench for the intern table.
// Depends on csit_pkg and the combining_sequence_intern_table RTL.
`timescale 1ns / 1ps

// Shadow copy of the intern table: predicts one result per accepted request
// and checks the results in order.
class intern_shadow;
    typedef struct {
        logic [31:0] code;
        logic [31:0] base;
        logic [3:0]  len;
        logic        is_new;
        logic        refuse;
        logic        bad;
    } intern_result_t;

    logic [31:0] e_prefix [csit_pkg::TABLE_ENTRIES];
    logic [20:0] e_suffix [csit_pkg::TABLE_ENTRIES];
    logic [20:0] e_base   [csit_pkg::TABLE_ENTRIES];
    logic [3:0]  e_len    [csit_pkg::TABLE_ENTRIES];
    int unsigned used;
    logic [3:0]  max_len;
    intern_result_t pending_results [$];
    intern_result_t last_predicted;
    int unsigned errors;

    function new();
        used = 0;
        max_len = csit_pkg::MAX_PREFIX_RESET;
        errors = 0;
    endfunction

    // works out the result of one accepted request and updates the table
    function void note_request(logic f, logic [31:0] code, logic [20:0] mark);
        intern_result_t r;
        logic [31:0] base;
        logic [3:0]  len;
        logic [31:0] n;
        int unsigned slot;
        bit found;
        r = '{code: code, base: code, len: 4'd1, is_new: 0, refuse: 0, bad: 0};
        found = 0;
        if (code >= csit_pkg::CODE_BASE) begin
            n = code - csit_pkg::CODE_BASE;
            if (n < 1 || n > used) begin
                r.bad = 1;
                found = 1;
            end else begin
                base = {11'd0, e_base[n - 1]};
                len  = e_len[n - 1];
            end
        end else begin
            base = code;
            len  = 4'd1;
        end
        if (!found) begin
            r.base = base;
            r.len  = len;
            if (f == csit_pkg::FUNC_APPEND) begin
                for (slot = 0; slot < used && !found; slot++) begin
                    if (e_prefix[slot] == code && e_suffix[slot] == mark) begin
                        r.code = csit_pkg::CODE_BASE + slot + 1;
                        r.base = {11'd0, e_base[slot]};
                        r.len  = e_len[slot];
                        found  = 1;
                    end
                end
                if (!found) begin
                    if (len > max_len || len >= csit_pkg::LEN_CAP
                        || used >= csit_pkg::TABLE_ENTRIES || base > 32'h001F_FFFF) begin
                        r.refuse = 1;
                    end else begin
                        e_prefix[used] = code;
                        e_suffix[used] = mark;
                        e_base[used]   = base[20:0];
                        e_len[used]    = len + 4'd1;
                        used++;
                        r.code   = csit_pkg::CODE_BASE + used;
                        r.len    = len + 4'd1;
                        r.is_new = 1;
                    end
                end
            end
        end
        last_predicted = r;
        pending_results.push_back(r);
    endfunction

    function void check_result(intern_result_t act);
        intern_result_t e;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending: code %h", $time, act.code);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (act.code !== e.code) begin
            $display("%0t: result_code exp %h got %h", $time, e.code, act.code);
            errors++;
        end
        if (act.base !== e.base) begin
            $display("%0t: base_char exp %h got %h", $time, e.base, act.base);
            errors++;
        end
        if (act.len !== e.len) begin
            $display("%0t: seq_length exp %0d got %0d", $time, e.len, act.len);
            errors++;
        end
        if (act.is_new !== e.is_new) begin
            $display("%0t: was_new exp %b got %b", $time, e.is_new, act.is_new);
            errors++;
        end
        if (act.refuse !== e.refuse) begin
            $display("%0t: refused exp %b got %b", $time, e.refuse, act.refuse);
            errors++;
        end
        if (act.bad !== e.bad) begin
            $display("%0t: invalid exp %b got %b", $time, e.bad, act.bad);
            errors++;
        end
    endfunction
endclass

module combining_sequence_intern_table_tb;
    import csit_pkg::*;

    localparam logic [0:0] ADDR_MAX_PREFIX = 1'b0;
    localparam int PHASE_ITEMS = 142;
    // keeps the fill count, and so the scan time of each append, bounded
    localparam int FILL_SOFT_CAP = 350;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        func;
    logic [31:0] seq_code;
    logic [20:0] mark_char;
    logic        done;
    logic [31:0] result_code;
    logic [31:0] base_char;
    logic [3:0]  seq_length;
    logic        was_new;
    logic        refused;
    logic        invalid;

    intern_shadow shadow;
    int unsigned  send_idle_pct;
    logic [31:0]  chain_code;
    logic [3:0]   phase_cfg [6] = '{4'd15, 4'd3, 4'd0, 4'd14, 4'd1, 4'd10};

    combining_sequence_intern_table uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .func(func), .seq_code(seq_code),
        .mark_char(mark_char), .done(done), .result_code(result_code),
        .base_char(base_char), .seq_length(seq_length), .was_new(was_new),
        .refused(refused), .invalid(invalid)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Results cannot be held off: every done cycle is a transfer, checked
    // against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_result('{code: result_code, base: base_char, len: seq_length,
                                  is_new: was_new, refuse: refused, bad: invalid});
    end

    // Block until every predicted result has been seen.
    task automatic drain_results();
        while (shadow.pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Register write: setup then access cycle; only while the block is idle.
    task automatic write_max_prefix(logic [3:0] value);
        drain_results();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_MAX_PREFIX;
        pwdata  = {28'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        shadow.max_len = value;
    endtask

    // One request transfer: hold start until an edge with busy low, then
    // optionally leave a random gap. Everything changes at the falling edge.
    task automatic send_request(logic f, logic [31:0] code, logic [20:0] mark);
        start     = 1'b1;
        func      = f;
        seq_code  = code;
        mark_char = mark;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        shadow.note_request(f, code, mark);
        @(negedge clk);
        start = 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            func      = 1'($urandom);
            seq_code  = $urandom;
            mark_char = 21'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Random request, biased towards codes already in the table and a small
    // pool of marks so that chains grow deep and lookups hit.
    task automatic send_random();
        logic        f;
        logic [31:0] code;
        logic [20:0] mark;
        int unsigned pick;
        int unsigned slot;
        f    = ($urandom_range(99) < 30) ? FUNC_QUERY : FUNC_APPEND;
        mark = ($urandom_range(99) < 70) ? 21'h000300 + 21'($urandom_range(7))
                                         : 21'($urandom);
        pick = $urandom_range(99);
        if (shadow.used != 0 && f == FUNC_APPEND && shadow.used >= FILL_SOFT_CAP
            && $urandom_range(99) < 75) begin
            // repeat a stored pair: a guaranteed hit, no new entry
            slot = $urandom_range(shadow.used - 1);
            code = shadow.e_prefix[slot];
            mark = shadow.e_suffix[slot];
        end else if (shadow.used != 0 && pick < 50) begin
            code = CODE_BASE + $urandom_range(shadow.used, 1);
        end else if (pick < 65) begin
            code = 32'h41 + $urandom_range(15);
        end else if (pick < 75) begin
            code = $urandom;
        end else if (pick < 85) begin
            // just past the valid composite range, or the bare base code
            code = ($urandom_range(1)) ? CODE_BASE : CODE_BASE + shadow.used + $urandom_range(3, 1);
        end else begin
            code = $urandom_range(32'h7FFF_FFFF, 32'h0020_0000);
        end
        send_request(f, code, mark);
    endtask

    initial
    begin
        int ph;
        int k;
        shadow        = new();
        send_idle_pct = 28;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = ADDR_MAX_PREFIX;
        pwdata    = 32'd0;
        start     = 1'b0;
        func      = FUNC_APPEND;
        seq_code  = 32'd0;
        mark_char = 21'd0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset limit first, then the deepest allowed chain.
        send_request(FUNC_QUERY, 32'h0000_0000, 21'd0);
        send_request(FUNC_QUERY, 32'h7FFF_FFFF, 21'h1FFFFF);
        send_request(FUNC_QUERY, CODE_BASE, 21'd0);           // bare base code
        send_request(FUNC_APPEND, 32'hFFFF_FFFF, 21'h000301); // past the fill
        send_request(FUNC_APPEND, 32'h0020_0000, 21'h000301); // too wide to store
        write_max_prefix(4'd14);
        send_request(FUNC_APPEND, 32'h0000_0041, 21'h1FFFFF); // mark above range
        send_request(FUNC_APPEND, 32'h0000_0041, 21'h1FFFFF); // same pair: hit
        chain_code = shadow.last_predicted.code;
        for (k = 0; k < 13; k++)
        begin
            send_request(FUNC_APPEND, chain_code, 21'h000300 + 21'(k));
            chain_code = shadow.last_predicted.code;
        end
        send_request(FUNC_APPEND, chain_code, 21'h000000);    // length 15: refused
        send_request(FUNC_QUERY, chain_code, 21'd0);
        // a tight limit still returns stored pairs, but refuses new ones
        write_max_prefix(4'd1);
        send_request(FUNC_APPEND, CODE_BASE + 1, 21'h000300);
        send_request(FUNC_APPEND, CODE_BASE + 1, 21'h000777);

        // Random phases across several limits; sender gaps vary by phase.
        for (ph = 0; ph < 6; ph++)
        begin
            write_max_prefix(phase_cfg[ph]);
            send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 61 : 0;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    drain_results();   // hold off until all results are in
                send_random();
            end
        end
        start = 1'b0;

        k = 0;
        while (shadow.pending_results.size() != 0 && k < 100000)
        begin
            @(negedge clk);
            k++;
        end
        repeat (20) @(negedge clk);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0)
            $display("** combining_sequence_intern_table: PASSED **");
        else
            $display("** combining_sequence_intern_table: FAILED **");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #(12 * 20000000);
        $display("** combining_sequence_intern_table: FAILED **");
        $finish;
    end
endmodule

>>> sim.f
src/csit_pkg.sv
src/csit_datapath.sv
src/csit_ctrl.sv
src/combining_sequence_intern_table.sv
sim/combining_sequence_intern_table_tb.sv
